@@ design/trsf_pkg.sv @@
// trsf_pkg: shared types and constants for the turbine rpm spike filter
// no dependencies; imported by turbine_rpm_spike_filter_top

package trsf_pkg;

    // field widths
    localparam int CAP_W   = 16;
    localparam int OVF_W   = 8;
    localparam int MODE_W  = 3;
    localparam int RPM_W   = 16;
    localparam int LIM_W   = 8;
    localparam int SCALE_W = 24;
    localparam int WGT_W   = 17;

    // signed period width and unsigned divisor width
    localparam int PER_W = 27;
    localparam int DIV_W = PER_W - 1;

    // stream word widths
    localparam int IN_BITS  = 2 * CAP_W + 2 * OVF_W + MODE_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = 2 * RPM_W + 3;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    // configuration port
    localparam int CFG_AW = 2;
    localparam int CFG_DW = SCALE_W;

    typedef enum logic [CFG_AW-1:0] {
        CFG_SPIKE_LIMIT     = 2'd0,
        CFG_RPM_SCALE       = 2'd1,
        CFG_OVERFLOW_WEIGHT = 2'd2
    } cfg_idx_t;

    localparam logic [LIM_W-1:0]   SPIKE_LIMIT_RST     = 8'd10;
    localparam logic [SCALE_W-1:0] RPM_SCALE_RST       = 24'd15000000;
    localparam logic [WGT_W-1:0]   OVERFLOW_WEIGHT_RST = 17'd65500;

    // turbine modes
    localparam logic [MODE_W-1:0] MODE_STARTUP  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_RAMPUP   = 3'd1;
    localparam logic [MODE_W-1:0] MODE_RUNNING  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_STOPPING = 3'd3;

    // consecutive ramp-up events that set the pitch flag
    localparam logic [1:0] PITCH_EVENTS = 2'd2;

    // event count, the current event included, at which filtering starts
    localparam int WARMUP_EVENTS_DEF = 2;

    // one quotient bit per divider step
    localparam int DIV_STEPS = SCALE_W;
    localparam int STEP_W    = $clog2(DIV_STEPS);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

endpackage

@@ design/turbine_rpm_spike_filter_top.sv @@
// turbine_rpm_spike_filter_top: capture events to filtered turbine rpm
// depends on trsf_pkg

// One capture event goes from acceptance to its loaded result word through
// ST_CALC, which forms the period (one 18x9 multiply), ST_DIV, the shared
// restoring divider that produces one quotient bit of rpm_scale / period per
// cycle, and ST_DONE for saturation, spike filtering and the pitch flag.
// s_tready is high only while the block is idle, so an event is taken only
// once the last one is done. The result sits in an output register, so the next
// event is taken while that word still waits on m_tready; a finished event
// waits in its last cycle until that register is free.
// A zero or negative period reports raw rpm 0 with bad_period set. Filtering
// starts once WARMUP_EVENTS events have been seen. Configuration writes on
// cfg_we are taken at once and should be made only while no event is in work.

module turbine_rpm_spike_filter_top
    import trsf_pkg::*;
#(
    parameter int WARMUP_EVENTS = WARMUP_EVENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    // input stream
    input  logic              s_tvalid,
    output logic              s_tready,
    // capture_now, capture_prev, overflows_now, overflows_prev, turbine_mode
    input  logic [IN_W-1:0]   s_tdata,
    // output stream
    output logic              m_tvalid,
    input  logic              m_tready,
    // reported_rpm, raw_rpm, spike_rejected, pitch_ready, bad_period
    output logic [OUT_W-1:0]  m_tdata,
    // configuration writes
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata
);

    localparam int WU_W = (WARMUP_EVENTS < 2) ? 1 : $clog2(WARMUP_EVENTS + 1);
    localparam logic [WU_W-1:0] WU_END  = WU_W'(WARMUP_EVENTS);
    localparam logic [WU_W-1:0] WU_ONE  = WU_W'(1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DIV_STEPS - 1);

    // configuration registers
    logic [LIM_W-1:0]   spike_limit_reg;
    logic [SCALE_W-1:0] rpm_scale_reg;
    logic [WGT_W-1:0]   overflow_weight_reg;

    // latched event
    logic [CAP_W-1:0]  cap_now_reg;
    logic [CAP_W-1:0]  cap_prev_reg;
    logic [OVF_W-1:0]  ovf_now_reg;
    logic [OVF_W-1:0]  ovf_prev_reg;
    logic [MODE_W-1:0] mode_reg;

    // divider
    logic [DIV_W-1:0]   divisor_reg;
    logic [DIV_W-1:0]   rem_reg;
    logic [SCALE_W-1:0] quo_reg;
    logic [STEP_W-1:0]  step_reg;
    logic               bad_reg;

    // filter state
    logic [WU_W-1:0]  warmup_reg;
    logic [RPM_W-1:0] last_rpm_reg;
    logic [RPM_W-1:0] held_rpm_reg;
    logic [1:0]       rampup_reg;
    logic             pitch_reg;

    // output register
    logic             m_tvalid_reg;
    logic [OUT_W-1:0] m_tdata_reg;

    state_t state_reg, state_next;

    logic in_fire;
    logic out_free;

    assign in_fire  = s_tvalid & s_tready;
    assign out_free = ~m_tvalid_reg | m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spike_limit_reg     <= SPIKE_LIMIT_RST;
            rpm_scale_reg       <= RPM_SCALE_RST;
            overflow_weight_reg <= OVERFLOW_WEIGHT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_SPIKE_LIMIT:     spike_limit_reg     <= cfg_wdata[LIM_W-1:0];
                CFG_RPM_SCALE:       rpm_scale_reg       <= cfg_wdata[SCALE_W-1:0];
                CFG_OVERFLOW_WEIGHT: overflow_weight_reg <= cfg_wdata[WGT_W-1:0];
                default:             ;
            endcase
        end
    end

    // period in ticks
    logic                    cap_gt;
    logic [OVF_W-1:0]        ovf_diff;
    logic signed [OVF_W:0]   ovf_mul;
    logic signed [CAP_W+1:0] base;
    logic signed [WGT_W:0]   weight_s;
    logic signed [PER_W-1:0] prod;
    logic signed [PER_W-1:0] period;

    always_comb
    begin
        cap_gt   = (cap_now_reg > cap_prev_reg);
        ovf_diff = ovf_now_reg - ovf_prev_reg;
        ovf_mul  = cap_gt ? $signed({1'b0, ovf_diff})
                          : $signed({1'b0, ovf_diff}) - 9'sd1;
        base     = $signed({2'b00, cap_now_reg}) - $signed({2'b00, cap_prev_reg})
                 + (cap_gt ? 18'sd1 : 18'sd65537);
        weight_s = $signed({1'b0, overflow_weight_reg});
        prod     = weight_s * ovf_mul;
        period   = {{(PER_W-CAP_W-2){base[CAP_W+1]}}, base} + prod;
    end

    // shared divider step: shift in one dividend bit, trial subtract
    logic [DIV_W:0]   rem_shift;
    logic [DIV_W+1:0] trial;
    logic             trial_ge;

    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[SCALE_W-1]};
        trial     = {1'b0, rem_shift} - {2'b00, divisor_reg};
        trial_ge  = ~trial[DIV_W+1];
    end

    // saturation and filtering for the finishing cycle
    logic [RPM_W-1:0] raw_rpm;
    logic [WU_W-1:0]  warmup_new;
    logic             filt_on;
    logic [RPM_W:0]   hi_bound;
    logic [RPM_W:0]   raw_plus;
    logic             is_spike;
    logic [RPM_W-1:0] last_new;
    logic [RPM_W-1:0] held_new;
    logic             rejected;
    logic [1:0]       rampup_new;
    logic             pitch_new;

    always_comb
    begin
        if (bad_reg)
            raw_rpm = '0;
        else if (|quo_reg[SCALE_W-1:RPM_W])
            raw_rpm = '1;
        else
            raw_rpm = quo_reg[RPM_W-1:0];

        warmup_new = (warmup_reg < WU_END) ? warmup_reg + WU_ONE : warmup_reg;
        filt_on    = (warmup_new == WU_END);

        hi_bound = {1'b0, last_rpm_reg} + {{(RPM_W-LIM_W+1){1'b0}}, spike_limit_reg};
        raw_plus = {1'b0, raw_rpm} + {{(RPM_W-LIM_W+1){1'b0}}, spike_limit_reg};
        is_spike = ({1'b0, raw_rpm} > hi_bound) || (raw_plus < {1'b0, last_rpm_reg});

        last_new = last_rpm_reg;
        held_new = held_rpm_reg;
        rejected = 1'b0;
        if (filt_on)
        begin
            case (mode_reg)
                MODE_RAMPUP, MODE_RUNNING:
                begin
                    // a spike reports the last accepted measurement
                    if (is_spike)
                    begin
                        rejected = 1'b1;
                        held_new = last_rpm_reg;
                    end
                    else
                    begin
                        last_new = raw_rpm;
                        held_new = raw_rpm;
                    end
                end
                MODE_STARTUP, MODE_STOPPING:
                begin
                    last_new = raw_rpm;
                    held_new = raw_rpm;
                end
                default:
                    last_new = raw_rpm;
            endcase
        end

        if (mode_reg == MODE_RAMPUP)
            rampup_new = (rampup_reg < PITCH_EVENTS) ? rampup_reg + 2'd1 : rampup_reg;
        else
            rampup_new = 2'd0;
        pitch_new = pitch_reg | (rampup_new == PITCH_EVENTS);
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_fire) state_next = ST_CALC;
            ST_CALC: state_next = ST_DIV;
            ST_DIV:  if (step_reg == '0) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // event latch and divider datapath
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cap_now_reg  <= s_tdata[CAP_W-1:0];
            cap_prev_reg <= s_tdata[2*CAP_W-1:CAP_W];
            ovf_now_reg  <= s_tdata[2*CAP_W+OVF_W-1:2*CAP_W];
            ovf_prev_reg <= s_tdata[2*CAP_W+2*OVF_W-1:2*CAP_W+OVF_W];
            mode_reg     <= s_tdata[IN_BITS-1:2*CAP_W+2*OVF_W];
        end

        if (state_reg == ST_CALC)
        begin
            divisor_reg <= period[DIV_W-1:0];
            bad_reg     <= (period <= 0);
            rem_reg     <= '0;
            quo_reg     <= rpm_scale_reg;
            step_reg    <= STEP_LAST;
        end
        else if (state_reg == ST_DIV)
        begin
            rem_reg  <= trial_ge ? trial[DIV_W-1:0] : rem_shift[DIV_W-1:0];
            quo_reg  <= {quo_reg[SCALE_W-2:0], trial_ge};
            step_reg <= step_reg - STEP_W'(1);
        end
    end

    // filter state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            warmup_reg   <= '0;
            last_rpm_reg <= '0;
            held_rpm_reg <= '0;
            rampup_reg   <= '0;
            pitch_reg    <= 1'b0;
        end
        else if (state_reg == ST_DONE && out_free)
        begin
            warmup_reg   <= warmup_new;
            last_rpm_reg <= last_new;
            held_rpm_reg <= held_new;
            rampup_reg   <= rampup_new;
            pitch_reg    <= pitch_new;
        end
    end

    // output word register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tvalid_reg <= 1'b0;
        else if (state_reg == ST_DONE && out_free)
            m_tvalid_reg <= 1'b1;
        else if (m_tready)
            m_tvalid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_DONE && out_free)
            m_tdata_reg <= {{(OUT_W-OUT_BITS){1'b0}}, bad_reg, pitch_new, rejected,
                            raw_rpm, held_new};
    end

endmodule

@@ tb/sv/rpm_event_checker.sv @@
`timescale 1ns / 100ps
// rpm_event_checker: predicts the result word of every accepted capture event
// and compares it field by field with the output stream; depends on trsf_pkg

module rpm_event_checker
    import trsf_pkg::*;
#(
    parameter int WARMUP_EVENTS = WARMUP_EVENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    input  logic              s_tready,
    // capture_now, capture_prev, overflows_now, overflows_prev, turbine_mode
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              m_tvalid,
    input  logic              m_tready,
    // reported_rpm, raw_rpm, spike_rejected, pitch_ready, bad_period
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_wdata,
    output int                mismatches,
    output int                outstanding
);

    typedef struct packed {
        logic [RPM_W-1:0] reported;
        logic [RPM_W-1:0] raw;
        logic             rejected;
        logic             pitch;
        logic             bad;
    } rpm_word_t;

    // register copies
    logic [LIM_W-1:0]   spike_lim;
    logic [SCALE_W-1:0] scale;
    logic [WGT_W-1:0]   weight;

    // filter state copies
    int                 warm_events;
    logic [RPM_W-1:0]   prev_rpm;
    logic [RPM_W-1:0]   shown_rpm;
    logic [1:0]         ramp_events;
    logic               pitch_set;

    rpm_word_t          expected_rpm_words[$];
    int                 miss_total;

    // period, division, spike filter and pitch flag for one capture event
    function automatic rpm_word_t predict_rpm_word(input logic [IN_W-1:0] w);
        logic [CAP_W-1:0] cap_now;
        logic [CAP_W-1:0] cap_prev;
        logic [OVF_W-1:0] ovf_diff;
        logic [MODE_W-1:0] mode;
        logic [RPM_W-1:0] old_rpm;
        longint           period;
        longint           quot;
        longint           lo_bound;
        longint           hi_bound;
        rpm_word_t        r;

        cap_now  = w[15:0];
        cap_prev = w[31:16];
        ovf_diff = w[39:32] - w[47:40];
        mode     = w[50:48];
        r        = '0;

        if (cap_now > cap_prev)
            period = longint'(cap_now) - longint'(cap_prev) + 1
                     + longint'(weight) * longint'(ovf_diff);
        else
            period = longint'(cap_now) - longint'(cap_prev) + 65537
                     + longint'(weight) * (longint'(ovf_diff) - 1);

        if (period <= 0)
        begin
            r.bad = 1'b1;
        end
        else
        begin
            quot  = longint'(scale) / period;
            r.raw = (quot > 65535) ? 16'hFFFF : quot[RPM_W-1:0];
        end

        if (warm_events < WARMUP_EVENTS)
            warm_events = warm_events + 1;

        // filter by mode once warm-up is over
        if (warm_events == WARMUP_EVENTS)
        begin
            old_rpm  = prev_rpm;
            prev_rpm = r.raw;
            if (mode == MODE_RAMPUP || mode == MODE_RUNNING)
            begin
                lo_bound = longint'(old_rpm) - longint'(spike_lim);
                hi_bound = longint'(old_rpm) + longint'(spike_lim);
                if (longint'(r.raw) > hi_bound || longint'(r.raw) < lo_bound)
                begin
                    shown_rpm  = old_rpm;
                    prev_rpm   = old_rpm;
                    r.rejected = 1'b1;
                end
                else
                begin
                    shown_rpm = r.raw;
                end
            end
            else if (mode == MODE_STARTUP || mode == MODE_STOPPING)
            begin
                shown_rpm = r.raw;
            end
        end

        // sticky pitch flag after consecutive ramp-up events
        if (mode == MODE_RAMPUP)
        begin
            if (ramp_events < PITCH_EVENTS)
                ramp_events = ramp_events + 1'b1;
        end
        else
        begin
            ramp_events = '0;
        end
        if (ramp_events == PITCH_EVENTS)
            pitch_set = 1'b1;

        r.reported = shown_rpm;
        r.pitch    = pitch_set;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rpm_word_t exp_w;
        rpm_word_t got_w;

        if (!rst_n)
        begin
            spike_lim   = SPIKE_LIMIT_RST;
            scale       = RPM_SCALE_RST;
            weight      = OVERFLOW_WEIGHT_RST;
            warm_events = 0;
            prev_rpm    = '0;
            shown_rpm   = '0;
            ramp_events = '0;
            pitch_set   = 1'b0;
            miss_total  = 0;
            expected_rpm_words.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            // result word against the oldest expectation
            if (m_tvalid && m_tready)
            begin
                got_w.reported = m_tdata[15:0];
                got_w.raw      = m_tdata[31:16];
                got_w.rejected = m_tdata[32];
                got_w.pitch    = m_tdata[33];
                got_w.bad      = m_tdata[34];
                if (expected_rpm_words.size() == 0)
                begin
                    miss_total = miss_total + 1;
                    if (miss_total <= 10)
                        $display("%0t: unexpected result word %h", $realtime, m_tdata);
                end
                else
                begin
                    exp_w = expected_rpm_words.pop_front();
                    if (got_w.reported !== exp_w.reported || got_w.raw !== exp_w.raw ||
                        got_w.rejected !== exp_w.rejected ||
                        got_w.pitch !== exp_w.pitch || got_w.bad !== exp_w.bad)
                    begin
                        miss_total = miss_total + 1;
                        if (miss_total <= 10)
                        begin
                            $write("%0t: mismatch exp rpm=%0d raw=%0d rej=%0b pitch=%0b bad=%0b",
                                   $realtime, exp_w.reported, exp_w.raw, exp_w.rejected,
                                   exp_w.pitch, exp_w.bad);
                            $display(" got rpm=%0d raw=%0d rej=%0b pitch=%0b bad=%0b",
                                     got_w.reported, got_w.raw, got_w.rejected,
                                     got_w.pitch, got_w.bad);
                        end
                    end
                end
            end

            // capture event in
            if (s_tvalid && s_tready)
                expected_rpm_words.push_back(predict_rpm_word(s_tdata));

            // register writes, masked to register width
            if (cfg_we)
            begin
                if (cfg_addr == CFG_SPIKE_LIMIT)
                    spike_lim = cfg_wdata[LIM_W-1:0];
                else if (cfg_addr == CFG_RPM_SCALE)
                    scale = cfg_wdata[SCALE_W-1:0];
                else if (cfg_addr == CFG_OVERFLOW_WEIGHT)
                    weight = cfg_wdata[WGT_W-1:0];
            end

            mismatches  <= miss_total;
            outstanding <= expected_rpm_words.size();
        end
    end

endmodule

@@ tb/sv/turbine_rpm_spike_filter_top_tb.sv @@
`timescale 1ns / 100ps
// turbine_rpm_spike_filter_top_tb: stimulus, register phases and verdict for
// the rpm spike filter; depends on trsf_pkg and rpm_event_checker

module turbine_rpm_spike_filter_top_tb;
    import trsf_pkg::*;

    localparam int LATENCY     = 27;
    localparam int HOLD_CYCLES = 300;
    localparam int STALL_LIMIT = 4000;

    // register index past the end of the map, writes are dropped
    localparam logic [CFG_AW-1:0] CFG_UNMAPPED = 2'd3;

    // modes outside the named four hold the reported value
    localparam logic [MODE_W-1:0] MODE_HOLD     = 3'd4;
    localparam logic [MODE_W-1:0] MODE_HOLD_MAX = 3'd7;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_BUSY_LIGHT,
        RX_BUSY_HEAVY,
        RX_PERIODIC
    } rx_style_t;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    // capture_now, capture_prev, overflows_now, overflows_prev, turbine_mode
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    // reported_rpm, raw_rpm, spike_rejected, pitch_ready, bad_period
    logic [OUT_W-1:0]  m_tdata;
    logic              cfg_we;
    logic [CFG_AW-1:0] cfg_addr;
    logic [CFG_DW-1:0] cfg_wdata;

    int                mismatches;
    int                outstanding;
    int                quiet_cycles = 0;

    // sender pacing
    bit                gaps_on;
    int                burst_left;
    int                holds_req;

    // shaft trace for well-formed event runs
    logic [23:0]       trace_timer;
    int                tick_gap;

    turbine_rpm_spike_filter_top #(
        .WARMUP_EVENTS (WARMUP_EVENTS_DEF)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    rpm_event_checker #(
        .WARMUP_EVENTS (WARMUP_EVENTS_DEF)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // watchdog on cycles with no word moving on either side
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    // receiver: changing stall styles plus requested long hold-offs
    initial
    begin
        rx_style_t rx_style;
        int        rx_left;
        int        holds_done;

        m_tready   = 1'b0;
        rx_style   = RX_OPEN;
        rx_left    = 0;
        holds_done = 0;
        do @(posedge clk); while (!rst_n);
        forever
        begin
            if (holds_req != holds_done)
            begin
                holds_done = holds_done + 1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (rx_left == 0)
            begin
                rx_style = rx_style_t'($urandom_range(0, 3));
                rx_left  = $urandom_range(16, 200);
            end
            rx_left = rx_left - 1;
            case (rx_style)
                RX_OPEN:       m_tready <= 1'b1;
                RX_BUSY_LIGHT: m_tready <= ($urandom_range(0, 3) != 0);
                RX_BUSY_HEAVY: m_tready <= ($urandom_range(0, 3) == 0);
                default:       m_tready <= (rx_left % 5 != 0);
            endcase
            @(posedge clk);
        end
    end

    // offer one capture event and wait until it is taken
    task automatic push_event(input logic [CAP_W-1:0] cap_now, input logic [CAP_W-1:0] cap_prev,
                              input logic [OVF_W-1:0] ovf_now, input logic [OVF_W-1:0] ovf_prev,
                              input logic [MODE_W-1:0] mode);
        logic [IN_W-1:0] w;

        if (gaps_on && burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 24)) @(posedge clk);
            burst_left = $urandom_range(1, 12);
        end
        w        = '0;
        w[15:0]  = cap_now;
        w[31:16] = cap_prev;
        w[39:32] = ovf_now;
        w[47:40] = ovf_prev;
        w[50:48] = mode;
        s_tvalid <= 1'b1;
        s_tdata  <= w;
        do @(posedge clk); while (!s_tready);
        if (burst_left > 0)
            burst_left = burst_left - 1;
    endtask

    // event with a given period in ticks, no overflow, no capture wrap
    task automatic push_period(input int period, input logic [MODE_W-1:0] mode);
        push_event(CAP_W'(1000 + period - 1), 16'd1000, 8'd0, 8'd0, mode);
    endtask

    // stop offering until every predicted word has come back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // new register setting with the block idle, plus a write to the unmapped index
    task automatic set_regs(input logic [CFG_DW-1:0] lim, input logic [CFG_DW-1:0] scale,
                            input logic [CFG_DW-1:0] wgt);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_SPIKE_LIMIT;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_addr  <= CFG_RPM_SCALE;
        cfg_wdata <= scale;
        @(posedge clk);
        cfg_addr  <= CFG_OVERFLOW_WEIGHT;
        cfg_wdata <= wgt;
        @(posedge clk);
        cfg_addr  <= CFG_UNMAPPED;
        cfg_wdata <= CFG_DW'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // mostly runs of consistent shaft events, the rest random noise
    task automatic run_random(input int count);
        int               done_items;
        int               run_len;
        int               drift;
        logic [23:0]      next_timer;
        logic [MODE_W-1:0] mode;

        done_items = 0;
        while (done_items < count)
        begin
            if ($urandom_range(0, 5) == 0)
                gaps_on = !gaps_on;
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0, 1:    mode = MODE_STARTUP;
                    2, 3, 4: mode = MODE_RAMPUP;
                    5, 6, 7: mode = MODE_RUNNING;
                    8:       mode = MODE_STOPPING;
                    default: mode = MODE_W'($urandom_range(MODE_HOLD, MODE_HOLD_MAX));
                endcase
                if ($urandom_range(0, 7) == 0)
                    tick_gap = $urandom_range(200, 60000);
                run_len = $urandom_range(3, 12);
                repeat (run_len)
                begin
                    // slow drift with an occasional jump
                    drift = tick_gap / 256 + 1;
                    if ($urandom_range(0, 9) == 0)
                        tick_gap = $urandom_range(0, 1) ? tick_gap * 2 : tick_gap / 2 + 1;
                    else
                        tick_gap = tick_gap + $urandom_range(0, 2 * drift) - drift;
                    if (tick_gap < 1)
                        tick_gap = 1;
                    if (tick_gap > 4000000)
                        tick_gap = 4000000;
                    next_timer = trace_timer + 24'(tick_gap);
                    push_event(next_timer[15:0], trace_timer[15:0],
                               next_timer[23:16], trace_timer[23:16], mode);
                    trace_timer = next_timer;
                    done_items  = done_items + 1;
                end
            end
            else
            begin
                push_event(CAP_W'($urandom_range(0, 65535)), CAP_W'($urandom_range(0, 65535)),
                           OVF_W'($urandom_range(0, 255)), OVF_W'($urandom_range(0, 255)),
                           MODE_W'($urandom_range(0, 7)));
                done_items = done_items + 1;
            end
        end
    endtask

    // stimulus and verdict
    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        cfg_we      = 1'b0;
        cfg_addr    = CFG_SPIKE_LIMIT;
        cfg_wdata   = '0;
        gaps_on     = 1'b1;
        burst_left  = 0;
        holds_req   = 0;
        trace_timer = '0;
        tick_gap    = 15000;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed events under reset register values
        push_event(16'd0, 16'd0, 8'd0, 8'd0, MODE_STARTUP);          // saturated quotient
        push_event(16'd0, 16'd37, 8'd0, 8'd0, MODE_STARTUP);         // zero period
        push_event(16'd0, 16'hFFFF, 8'd0, 8'd0, MODE_STARTUP);       // negative period
        push_period(15000, MODE_STARTUP);
        push_period(14850, MODE_RAMPUP);                             // upper edge, taken
        push_period(15000, MODE_RAMPUP);                             // lower edge, pitch set
        push_period(14830, MODE_RAMPUP);                             // one above, rejected
        push_period(15150, MODE_RUNNING);
        push_period(16000, MODE_RUNNING);                            // drop, rejected
        push_event(16'hFFFF, 16'd0, 8'hFF, 8'd0, MODE_RUNNING);      // longest period
        push_period(15000, MODE_HOLD);
        push_event(16'd0, 16'hFFFF, 8'd1, 8'd0, MODE_HOLD_MAX);      // capture wrap
        push_event(16'hFFFF, 16'hFFFF, 8'd0, 8'hFF, MODE_STOPPING);  // overflow wrap
        push_event(16'h5555, 16'hAAAA, 8'hAA, 8'h55, 3'd5);
        push_event(16'hAAAA, 16'h5555, 8'h55, 8'hAA, 3'd6);
        push_event(16'd1, 16'd0, 8'd0, 8'd0, MODE_STARTUP);

        // reset values, long receiver hold with the sender still offering
        run_random(40);
        holds_req <= holds_req + 1;
        gaps_on = 1'b0;
        run_random(20);
        drain_results();
        gaps_on = 1'b1;
        run_random(40);

        // no spike tolerance, largest scale, no overflow weight
        set_regs(24'd0, 24'hFFFFFF, 24'd0);
        run_random(100);

        // widest tolerance, smallest nonzero scale, overflow weight of 65536
        set_regs(24'hFFFF00 | 24'd255, 24'd1, 24'd65536);
        run_random(80);

        // zero scale, weight above range, junk in unused bits
        set_regs(24'hA5A500 | CFG_DW'($urandom_range(0, 255)), 24'd0, 24'hFFFFFF);
        run_random(80);

        // typical field setting
        set_regs(CFG_DW'($urandom_range(5, 60)), CFG_DW'($urandom_range(1, 16777215)),
                 CFG_DW'($urandom_range(0, 65536)));
        run_random(140);

        drain_results();
        repeat (LATENCY + 5) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

@@ turbine_rpm_spike_filter_top.f @@
design/trsf_pkg.sv
design/turbine_rpm_spike_filter_top.sv
tb/sv/rpm_event_checker.sv
tb/sv/turbine_rpm_spike_filter_top_tb.sv
